>>> sv/wlcs_pkg.sv
package wlcs_pkg;

   // item field widths
   localparam int ADDR_W  = 7;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 32;
   localparam int DIV_W   = 8;
   localparam int IDX_W   = 3;
   localparam int POS_W   = 3;

   // operation codes on req_op
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // result kinds on rsp_kind
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_SCAN  = 1'b1;

   // record layout
   localparam logic [BYTE_W-1:0]  CHECK_SEED    = 8'h5A;
   localparam logic [DIV_W-1:0]   DIVIDER_RESET = 8'd4;
   localparam logic [IDX_W-1:0]   LAST_IDX      = 3'd4;
   localparam logic [POS_W-1:0]   LAST_DATA_POS = 3'd4;
   localparam logic [ADDR_W-1:0]  REC_BYTES     = 7'd5;

   // one burst of results, handed from the core to the emitter
   typedef struct packed {
      logic                 is_scan;
      logic [COUNT_W-1:0]   count;
      logic [ADDR_W-1:0]    base;
      logic [COUNT_W-1:0]   value;
      logic [BYTE_W-1:0]    check_byte;
   } burst_type;

endpackage

>>> sv/wlcs_core.sv
module wlcs_core #(
   parameter int SLOTS = 25
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [wlcs_pkg::BYTE_W-1:0]     req_read_byte,
   input  logic                            req_counter_changed,
   input  logic [wlcs_pkg::COUNT_W-1:0]    req_counter_value,
   input  logic                            csr_write_enable,
   input  logic [wlcs_pkg::DIV_W-1:0]      csr_write_data,
   input  logic                            emit_ready,
   output logic                            load_valid,
   output wlcs_pkg::burst_type             load_burst
);
   import wlcs_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
   localparam int PROD_W = SLOT_W + 3;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic                 op_ff;
   logic [BYTE_W-1:0]    byte_ff;
   logic                 changed_ff;
   logic [COUNT_W-1:0]   value_ff;

   // counter and scan state
   logic [DIV_W-1:0]     divider_ff, divider_in;
   logic [SLOT_W-1:0]    write_slot_ff, write_slot_in;
   logic [DIV_W-1:0]     countdown_ff, countdown_in;
   logic [POS_W-1:0]     scan_pos_ff, scan_pos_in;
   logic [SLOT_W-1:0]    scan_slot_ff, scan_slot_in;
   logic [COUNT_W-1:0]   scan_value_ff, scan_value_in;
   logic [BYTE_W-1:0]    scan_check_ff, scan_check_in;
   logic [COUNT_W-1:0]   best_ff, best_in;
   logic                 scan_done_ff, scan_done_in;

   logic                 need_burst;
   logic                 move;
   logic                 accept;
   logic [BYTE_W-1:0]    scan_d;
   logic [BYTE_W-1:0]    chk_next;
   logic [DIV_W-1:0]     cd_dec;
   logic [BYTE_W-1:0]    value_xor;
   logic [PROD_W-1:0]    base_prod;
   logic [SLOT_W-1:0]    ws_next;
   logic [SLOT_W-1:0]    ss_next;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] n;
      n = (s == SLOT_LAST) ? '0 : s + 1'b1;
      return n;
   endfunction

   // per-item decode
   always_comb begin
      scan_d    = ~byte_ff;
      chk_next  = scan_check_ff ^ scan_d;
      cd_dec    = countdown_ff - 1'b1;
      value_xor = CHECK_SEED ^ value_ff[7:0] ^ value_ff[15:8]
                  ^ value_ff[23:16] ^ value_ff[31:24];
      base_prod = PROD_W'(write_slot_ff) * PROD_W'(5);
      ws_next   = next_slot(write_slot_ff);
      ss_next   = next_slot(scan_slot_ff);
      unique case (op_ff)
         OP_SCAN: need_burst = !scan_done_ff && (scan_pos_ff == LAST_DATA_POS);
         OP_TICK: need_burst = (countdown_ff != '0) && (cd_dec == '0);
         default: need_burst = 1'b0;
      endcase
   end

   // handshake
   assign move      = in_valid_ff && (!need_burst || emit_ready);
   assign req_stall = in_valid_ff && !move;
   assign accept    = req_valid && !req_stall;
   assign load_valid = move && need_burst;

   always_comb begin
      in_valid_in = accept ? 1'b1 : (move ? 1'b0 : in_valid_ff);
   end

   // burst descriptor
   always_comb begin
      load_burst            = '0;
      load_burst.is_scan    = (op_ff == OP_SCAN);
      load_burst.count      = best_in;
      load_burst.base       = base_prod[ADDR_W-1:0];
      load_burst.value      = value_ff;
      load_burst.check_byte = ~value_xor;
      if (op_ff == OP_TICK) begin
         load_burst.count = '0;
      end else begin
         load_burst.base  = '0;
         load_burst.value = '0;
         load_burst.check_byte = '0;
      end
   end

   // state update
   always_comb begin
      divider_in    = csr_write_enable ? csr_write_data : divider_ff;
      write_slot_in = write_slot_ff;
      countdown_in  = countdown_ff;
      scan_pos_in   = scan_pos_ff;
      scan_slot_in  = scan_slot_ff;
      scan_value_in = scan_value_ff;
      scan_check_in = scan_check_ff;
      best_in       = best_ff;
      scan_done_in  = scan_done_ff;
      if (move) begin
         unique case (op_ff)
            OP_SCAN: begin
               if (!scan_done_ff) begin
                  scan_check_in = chk_next;
                  if (scan_pos_ff != LAST_DATA_POS) begin
                     scan_value_in = {scan_value_ff[COUNT_W-BYTE_W-1:0], scan_d};
                     scan_pos_in   = scan_pos_ff + 1'b1;
                  end else begin
                     // record end: take it if valid and larger
                     if (chk_next == '0 && scan_value_ff > best_ff) begin
                        best_in       = scan_value_ff;
                        write_slot_in = ss_next;
                     end
                     scan_pos_in   = '0;
                     scan_value_in = '0;
                     scan_check_in = CHECK_SEED;
                     scan_slot_in  = ss_next;
                     scan_done_in  = (scan_slot_ff == SLOT_LAST);
                  end
               end
            end
            OP_TICK: begin
               if (countdown_ff != '0) begin
                  countdown_in = cd_dec;
                  if (cd_dec == '0) begin
                     write_slot_in = ws_next;
                  end
               end else if (changed_ff) begin
                  countdown_in = divider_ff;
               end
            end
            default: begin
               countdown_in = countdown_ff;
            end
         endcase
      end
   end

   // payload of the input register
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_op;
         byte_ff    <= req_read_byte;
         changed_ff <= req_counter_changed;
         value_ff   <= req_counter_value;
      end
   end

   // control, counter and scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         divider_ff    <= DIVIDER_RESET;
         write_slot_ff <= '0;
         countdown_ff  <= '0;
         scan_pos_ff   <= '0;
         scan_slot_ff  <= '0;
         scan_value_ff <= '0;
         scan_check_ff <= CHECK_SEED;
         best_ff       <= '0;
         scan_done_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         divider_ff    <= divider_in;
         write_slot_ff <= write_slot_in;
         countdown_ff  <= countdown_in;
         scan_pos_ff   <= scan_pos_in;
         scan_slot_ff  <= scan_slot_in;
         scan_value_ff <= scan_value_in;
         scan_check_ff <= scan_check_in;
         best_ff       <= best_in;
         scan_done_ff  <= scan_done_in;
      end
   end

endmodule

>>> sv/wlcs_emit.sv
module wlcs_emit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load_valid,
   input  wlcs_pkg::burst_type             load_burst,
   output logic                            emit_ready,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_kind,
   output logic [wlcs_pkg::ADDR_W-1:0]     rsp_write_addr,
   output logic [wlcs_pkg::BYTE_W-1:0]     rsp_write_data,
   output logic                            rsp_last,
   output logic [wlcs_pkg::COUNT_W-1:0]    rsp_recovered_count
);
   import wlcs_pkg::*;

   logic                busy_ff, busy_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   burst_type           burst_ff;
   logic                take;
   logic                done_one;

   assign take       = busy_ff && !rsp_stall;
   assign done_one   = take && (burst_ff.is_scan || idx_ff == LAST_IDX);
   assign emit_ready = !busy_ff || done_one;

   // burst sequencing
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load_valid) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (done_one) begin
         busy_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid) begin
         burst_ff <= load_burst;
      end
   end

   // result fields: low byte first, check byte last
   assign rsp_valid = busy_ff;
   always_comb begin
      rsp_kind            = burst_ff.is_scan ? KIND_SCAN : KIND_WRITE;
      rsp_recovered_count = burst_ff.count;
      rsp_last            = 1'b0;
      unique case (idx_ff)
         3'd0: begin
            rsp_write_addr = burst_ff.base + 7'd3;
            rsp_write_data = ~burst_ff.value[7:0];
         end
         3'd1: begin
            rsp_write_addr = burst_ff.base + 7'd2;
            rsp_write_data = ~burst_ff.value[15:8];
         end
         3'd2: begin
            rsp_write_addr = burst_ff.base + 7'd1;
            rsp_write_data = ~burst_ff.value[23:16];
         end
         3'd3: begin
            rsp_write_addr = burst_ff.base;
            rsp_write_data = ~burst_ff.value[31:24];
         end
         default: begin
            rsp_write_addr = burst_ff.base + 7'd4;
            rsp_write_data = burst_ff.check_byte;
            rsp_last       = 1'b1;
         end
      endcase
      if (burst_ff.is_scan) begin
         rsp_write_addr = '0;
         rsp_write_data = '0;
         rsp_last       = 1'b0;
      end
   end

endmodule

>>> sv/wear_levelled_counter_store.sv
// Wear-levelled counter store: keeps a 32-bit counter in a ring of SLOTS
// five-byte records in byte storage.
// Input channel (req_*): op 0 feeds one stored byte of the start-up scan, in
// address order; op 1 is a timer tick carrying counter_changed/counter_value.
// Result channel (rsp_*): kind 1 reports the best count after each scanned
// record; kind 0 is a storage byte write, five per record, last marks the
// check byte.
// csr_write_enable/csr_write_data load write_divider (ticks from a counter
// change to the write of its record); change it only while the block is idle.
// Timing: an item waits in the input register and its first result is shown
// in the cycle after the item moves on. Items that give no result or one
// result go at one per cycle while rsp_stall is low; a record write holds the
// result register for its five byte writes, one per cycle while not stalled.
// A stalled result holds its fields; new items queue in the input register
// and req_stall rises only when that register cannot hand on its item.
// Reset (synchronous): divider 4, scan restarts at slot 0, no countdown,
// write slot 0, nothing pending.
module wear_levelled_counter_store #(
   parameter int SLOTS = 25
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [wlcs_pkg::BYTE_W-1:0]     req_read_byte,
   input  logic                            req_counter_changed,
   input  logic [wlcs_pkg::COUNT_W-1:0]    req_counter_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_kind,
   output logic [wlcs_pkg::ADDR_W-1:0]     rsp_write_addr,
   output logic [wlcs_pkg::BYTE_W-1:0]     rsp_write_data,
   output logic                            rsp_last,
   output logic [wlcs_pkg::COUNT_W-1:0]    rsp_recovered_count,
   input  logic                            csr_write_enable,
   input  logic [wlcs_pkg::DIV_W-1:0]      csr_write_data
);
   import wlcs_pkg::*;

   logic        emit_ready;
   logic        load_valid;
   burst_type   load_burst;

   // state update and input register
   wlcs_core #(
      .SLOTS(SLOTS)
   ) u_core (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_read_byte       (req_read_byte),
      .req_counter_changed (req_counter_changed),
      .req_counter_value   (req_counter_value),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .emit_ready          (emit_ready),
      .load_valid          (load_valid),
      .load_burst          (load_burst)
   );

   // result register and byte sequencer
   wlcs_emit u_emit (
      .clock               (clock),
      .reset               (reset),
      .load_valid          (load_valid),
      .load_burst          (load_burst),
      .emit_ready          (emit_ready),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_write_addr      (rsp_write_addr),
      .rsp_write_data      (rsp_write_data),
      .rsp_last            (rsp_last),
      .rsp_recovered_count (rsp_recovered_count)
   );

endmodule

>>> test/wlcs_monitor.sv
module wlcs_monitor #(
   parameter int SLOTS = 25
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic                         req_op,
   input  logic [wlcs_pkg::BYTE_W-1:0]  req_read_byte,
   input  logic                         req_counter_changed,
   input  logic [wlcs_pkg::COUNT_W-1:0] req_counter_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic                         rsp_kind,
   input  logic [wlcs_pkg::ADDR_W-1:0]  rsp_write_addr,
   input  logic [wlcs_pkg::BYTE_W-1:0]  rsp_write_data,
   input  logic                         rsp_last,
   input  logic [wlcs_pkg::COUNT_W-1:0] rsp_recovered_count,
   input  logic                         csr_write_enable,
   input  logic [wlcs_pkg::DIV_W-1:0]   csr_write_data,
   output int                           failures,
   output int                           pending
);
   import wlcs_pkg::*;

   // one result item as the block should present it
   typedef struct packed {
      logic               kind;
      logic [ADDR_W-1:0]  addr;
      logic [BYTE_W-1:0]  data;
      logic               last;
      logic [COUNT_W-1:0] count;
   } rsp_item_type;

   rsp_item_type owed_rsp[$];

   // shadow copy of the block's state
   logic [DIV_W-1:0]   divider;
   logic [4:0]         write_slot;
   logic [DIV_W-1:0]   countdown;
   logic [POS_W-1:0]   scan_pos;
   logic [4:0]         scan_slot;
   logic [COUNT_W-1:0] scan_value;
   logic [BYTE_W-1:0]  scan_check;
   logic [COUNT_W-1:0] best_count;
   logic               scan_done;

   function automatic logic [4:0] slot_after(logic [4:0] s);
      if (int'(s) + 1 >= SLOTS) return '0;
      return s + 5'd1;
   endfunction

   // one stored byte of the start-up scan; a record end reports the best count
   task automatic predict_scan_byte(logic [BYTE_W-1:0] raw);
      logic [BYTE_W-1:0] d;
      if (scan_done) return;
      d = ~raw;
      scan_check = scan_check ^ d;
      if (scan_pos < LAST_DATA_POS) begin
         scan_value = {scan_value[COUNT_W-9:0], d};
         scan_pos = scan_pos + 3'd1;
         return;
      end
      if (scan_check == '0 && scan_value > best_count) begin
         best_count = scan_value;
         write_slot = slot_after(scan_slot);
      end
      owed_rsp.push_back('{KIND_SCAN, '0, '0, 1'b0, best_count});
      scan_pos = '0;
      scan_value = '0;
      scan_check = CHECK_SEED;
      scan_slot = scan_slot + 5'd1;
      if (int'(scan_slot) >= SLOTS) scan_done = 1'b1;
   endtask

   // timer tick: count down, and at zero write the record low byte first
   task automatic predict_tick(logic changed, logic [COUNT_W-1:0] value);
      logic [ADDR_W-1:0] base;
      logic [BYTE_W-1:0] chk;
      logic [BYTE_W-1:0] b;
      if (countdown != '0) begin
         countdown = countdown - 8'd1;
         if (countdown != '0) return;
         base = REC_BYTES * write_slot;
         chk = CHECK_SEED;
         for (int i = 0; i < 4; i++) begin
            b = value[8*i +: 8];
            chk = chk ^ b;
            owed_rsp.push_back('{KIND_WRITE, base + ADDR_W'(3 - i), ~b, 1'b0, '0});
         end
         owed_rsp.push_back('{KIND_WRITE, base + ADDR_W'(LAST_IDX), ~chk, 1'b1, '0});
         write_slot = slot_after(write_slot);
      end else if (changed) begin
         countdown = divider;
      end
   endtask

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         failures++;
      end
   endtask

   // results are compared before the item of the same edge is predicted
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         owed_rsp.delete();
         divider = DIVIDER_RESET;
         write_slot = '0;
         countdown = '0;
         scan_pos = '0;
         scan_slot = '0;
         scan_value = '0;
         scan_check = CHECK_SEED;
         best_count = '0;
         scan_done = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_rsp.size() == 0) begin
               $error("result with none due: kind %0d addr 0x%0h data 0x%0h count 0x%0h",
                      rsp_kind, rsp_write_addr, rsp_write_data, rsp_recovered_count);
               failures++;
            end else begin
               want = owed_rsp.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("write_addr", want.addr, rsp_write_addr);
               check_field("write_data", want.data, rsp_write_data);
               check_field("last", want.last, rsp_last);
               check_field("recovered_count", want.count, rsp_recovered_count);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_op == OP_SCAN) predict_scan_byte(req_read_byte);
            else predict_tick(req_counter_changed, req_counter_value);
         end
         if (csr_write_enable) divider = csr_write_data;
      end
      pending <= owed_rsp.size();
   end

endmodule

>>> test/tb_wear_levelled_counter_store.sv
module tb_wear_levelled_counter_store;
   import wlcs_pkg::*;

   localparam int SLOTS         = 25;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 12;

   logic               clock;
   logic               reset               = 1'b1;
   logic               req_valid           = 1'b0;
   logic               req_stall;
   logic               req_op              = OP_SCAN;
   logic [BYTE_W-1:0]  req_read_byte       = '0;
   logic               req_counter_changed = 1'b0;
   logic [COUNT_W-1:0] req_counter_value   = '0;
   logic               rsp_valid;
   logic               rsp_stall           = 1'b0;
   logic               rsp_kind;
   logic [ADDR_W-1:0]  rsp_write_addr;
   logic [BYTE_W-1:0]  rsp_write_data;
   logic               rsp_last;
   logic [COUNT_W-1:0] rsp_recovered_count;
   logic               csr_write_enable    = 1'b0;
   logic [DIV_W-1:0]   csr_write_data      = '0;
   logic               calm                = 1'b0;
   int                 failures;
   int                 pending;
   int                 cycles              = 0;

   wear_levelled_counter_store #(
      .SLOTS(SLOTS)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_read_byte       (req_read_byte),
      .req_counter_changed (req_counter_changed),
      .req_counter_value   (req_counter_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_write_addr      (rsp_write_addr),
      .rsp_write_data      (rsp_write_data),
      .rsp_last            (rsp_last),
      .rsp_recovered_count (rsp_recovered_count),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   wlcs_monitor #(
      .SLOTS(SLOTS)
   ) i_monitor (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_read_byte       (req_read_byte),
      .req_counter_changed (req_counter_changed),
      .req_counter_value   (req_counter_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_write_addr      (rsp_write_addr),
      .rsp_write_data      (rsp_write_data),
      .rsp_last            (rsp_last),
      .rsp_recovered_count (rsp_recovered_count),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .failures            (failures),
      .pending             (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result side backpressure, off during the calm stretch
   always @(posedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(0, 99) < 9);
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // present one item, with an occasional gap first, and hold it until taken
   task automatic send_item(logic op, logic [BYTE_W-1:0] rbyte, logic changed,
                            logic [COUNT_W-1:0] value);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < 9) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_op              <= op;
      req_read_byte       <= rbyte;
      req_counter_changed <= changed;
      req_counter_value   <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // unused fields carry noise
   task automatic send_scan(logic [BYTE_W-1:0] rbyte);
      send_item(OP_SCAN, rbyte, 1'($urandom), $urandom);
   endtask

   task automatic send_tick(logic changed, logic [COUNT_W-1:0] value);
      send_item(OP_TICK, 8'($urandom), changed, value);
   endtask

   function automatic logic [COUNT_W-1:0] rand_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return COUNT_W'($urandom_range(0, 300));
         default: return $urandom;
      endcase
   endfunction

   // one stored record: complemented value MSB first, then the check byte
   task automatic scan_record(logic [COUNT_W-1:0] value, logic corrupt, int tick_pct);
      logic [BYTE_W-1:0] rec [5];
      logic [BYTE_W-1:0] chk;
      int k;
      chk = CHECK_SEED;
      for (k = 0; k < 4; k++) begin
         rec[k] = ~value[31 - 8*k -: 8];
         chk = chk ^ value[31 - 8*k -: 8];
      end
      rec[4] = ~chk;
      if (corrupt) begin
         k = $urandom_range(0, 4);
         rec[k] = rec[k] ^ 8'(1 << $urandom_range(0, 7));
      end
      for (k = 0; k < 5; k++) begin
         if ($urandom_range(0, 99) < tick_pct)
            send_tick($urandom_range(0, 3) == 0, rand_word());
         send_scan(rec[k]);
      end
   endtask

   // wait until every result is in and the input register has drained
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_divider(logic [DIV_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [COUNT_W-1:0] value;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset divider: a change mid-countdown is ignored, all-ones lands in slot 0
      send_tick(1'b1, 32'h0);
      send_tick(1'b1, $urandom);
      send_tick(1'b0, $urandom);
      send_tick(1'b0, $urandom);
      send_tick(1'b0, 32'hFFFF_FFFF);
      // zero record is valid but never taken
      scan_record(32'h0, 1'b0, 0);
      send_tick(1'b1, $urandom);
      repeat (3) send_tick(1'b0, $urandom);
      send_tick(1'b0, 32'h0);
      scan_record(32'h8000_0001, 1'b0, 0);
      // larger value, broken check byte: must be rejected
      scan_record(32'hFFFF_FFFE, 1'b1, 0);

      // rest of the ring, ticks mixed in; the last slot holds the maximum,
      // and the second half runs with no idling on either side
      for (int s = 3; s < SLOTS; s++) begin
         if (s == SLOTS / 2) calm <= 1'b1;
         if (s == SLOTS - 1) value = '1;
         else if ($urandom_range(0, 2) == 0) value = rand_word();
         else value = 32'h8000_0000 + 32'(s * 7) + COUNT_W'($urandom_range(0, 6));
         scan_record(value, (s != SLOTS - 1) && ($urandom_range(0, 4) == 0), 5);
      end
      calm <= 1'b0;

      // scan bytes after the ring is complete are dropped
      repeat (2) send_scan($urandom);
      repeat (2) send_tick(1'b0, rand_word());

      // shortest countdown, no idling on either side
      settle();
      set_divider(8'd1);
      calm <= 1'b1;
      repeat (8) send_tick($urandom_range(0, 4) != 0, rand_word());
      calm <= 1'b0;

      // zero divider never schedules a write
      settle();
      set_divider(8'd0);
      repeat (4) send_tick($urandom_range(0, 1), rand_word());

      settle();
      set_divider(8'($urandom_range(2, 9)));
      repeat (8) send_tick($urandom_range(0, 1), rand_word());

      // longest divider loads a full countdown
      settle();
      set_divider(8'd255);
      send_tick(1'b1, rand_word());
      send_tick(1'b0, rand_word());

      settle();
      if (failures == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

>>> sim.f
sv/wlcs_pkg.sv
sv/wlcs_core.sv
sv/wlcs_emit.sv
sv/wear_levelled_counter_store.sv
test/wlcs_monitor.sv
test/tb_wear_levelled_counter_store.sv
